// File: hw/rtl/pdps_pkg.sv
// Shared types and constants for the PID position drive step block.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package pdps_pkg;

    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 7;
    localparam int THRESH_W  = 16;
    localparam int POWER_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd6;

    // Register values after reset.
    localparam logic [LIMIT_W-1:0]  MAX_POWER_RST  = 7'd121;
    localparam logic [LIMIT_W-1:0]  MIN_POWER_RST  = 7'd40;
    localparam logic [THRESH_W-1:0] INT_THRESH_RST = 16'd50;
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd192;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd0;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gain_cfg;

    typedef struct packed {
        logic [LIMIT_W-1:0] mag_hi;
        logic [LIMIT_W-1:0] mag_lo;
    } t_limit_cfg;

endpackage

// File: hw/rtl/pdps_err_integ.sv
// Error, integral and derivative stage; holds the controller state.
// Depends on pdps_pkg for the threshold width.
`timescale 1ns / 1ps

module pdps_err_integ #(
    parameter int POS_W = 16,
    parameter int INT_W = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic signed [POS_W-1:0]             i_position,
    input  logic                                i_restart,
    input  logic signed [POS_W-1:0]             i_target,
    input  logic [pdps_pkg::THRESH_W-1:0]       i_threshold,
    output logic signed [POS_W:0]               o_err,
    output logic signed [INT_W-1:0]             o_integral,
    output logic signed [POS_W+1:0]             o_deriv,
    output logic                                o_zero
);
    import pdps_pkg::*;

    localparam int ERR_W = POS_W + 1;
    localparam int DER_W = POS_W + 2;
    localparam int CMP_W = (ERR_W > THRESH_W + 1) ? ERR_W : THRESH_W + 1;
    localparam int ACC_W = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;

    localparam logic signed [ACC_W-1:0] ILIM_HI =
        ACC_W'($signed({1'b0, {(INT_W-1){1'b1}}}));
    localparam logic signed [ACC_W-1:0] ILIM_LO =
        ACC_W'($signed({1'b1, {(INT_W-1){1'b0}}}));

    // The stored error of the last step is the previous error.
    logic signed [ERR_W-1:0] r_err,      n_err;
    logic signed [INT_W-1:0] r_integral, n_integral;
    logic signed [DER_W-1:0] r_deriv,    n_deriv;
    logic                    r_zero,     n_zero;

    logic signed [ERR_W-1:0] prev_eff;
    logic signed [INT_W-1:0] integ_eff;
    logic signed [CMP_W-1:0] err_cmp;
    logic signed [CMP_W-1:0] thr_cmp;
    logic signed [ACC_W-1:0] acc;

    always_comb begin
        prev_eff  = i_restart ? '0 : r_err;
        integ_eff = i_restart ? '0 : r_integral;
        n_err     = ERR_W'(i_target) - ERR_W'(i_position);
        n_zero    = (n_err == '0);
        err_cmp   = CMP_W'(n_err);
        thr_cmp   = $signed(CMP_W'(i_threshold));
        acc       = ACC_W'(integ_eff) + ACC_W'(n_err);
        if (err_cmp > thr_cmp) begin
            n_integral = '0;
        end else if (acc > ILIM_HI) begin
            n_integral = INT_W'(ILIM_HI);
        end else if (acc < ILIM_LO) begin
            n_integral = INT_W'(ILIM_LO);
        end else begin
            n_integral = INT_W'(acc);
        end
        n_deriv = DER_W'(n_err) - DER_W'(prev_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err      <= '0;
            r_integral <= '0;
        end else if (i_step) begin
            r_err      <= n_err;
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_deriv <= n_deriv;
            r_zero  <= n_zero;
        end
    end

    assign o_err      = r_err;
    assign o_integral = r_integral;
    assign o_deriv    = r_deriv;
    assign o_zero     = r_zero;

endmodule

// File: hw/rtl/pdps_gain_mul.sv
// Gain multiply stage: three signed-by-unsigned products, registered.
// Depends on pdps_pkg for the gain struct.
`timescale 1ns / 1ps

module pdps_gain_mul #(
    parameter int POS_W = 16,
    parameter int INT_W = 24
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic signed [POS_W:0]                        i_err,
    input  logic signed [INT_W-1:0]                      i_integral,
    input  logic signed [POS_W+1:0]                      i_deriv,
    input  logic                                         i_zero,
    input  pdps_pkg::t_gain_cfg                          i_gain,
    output logic signed [POS_W+pdps_pkg::GAIN_W+1:0]     o_p_term,
    output logic signed [INT_W+pdps_pkg::GAIN_W:0]       o_i_term,
    output logic signed [POS_W+pdps_pkg::GAIN_W+2:0]     o_d_term,
    output logic                                         o_zero
);
    import pdps_pkg::*;

    localparam int PE_W = POS_W + GAIN_W + 2;
    localparam int PI_W = INT_W + GAIN_W + 1;
    localparam int PD_W = POS_W + GAIN_W + 3;

    logic signed [PE_W-1:0] r_p_term, n_p_term;
    logic signed [PI_W-1:0] r_i_term, n_i_term;
    logic signed [PD_W-1:0] r_d_term, n_d_term;
    logic                   r_zero;

    always_comb begin
        n_p_term = PE_W'(i_err)      * PE_W'($signed({1'b0, i_gain.prop}));
        n_i_term = PI_W'(i_integral) * PI_W'($signed({1'b0, i_gain.integ}));
        n_d_term = PD_W'(i_deriv)    * PD_W'($signed({1'b0, i_gain.deriv}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_term <= n_p_term;
            r_i_term <= n_i_term;
            r_d_term <= n_d_term;
            r_zero   <= i_zero;
        end
    end

    assign o_p_term = r_p_term;
    assign o_i_term = r_i_term;
    assign o_d_term = r_d_term;
    assign o_zero   = r_zero;

endmodule

// File: hw/rtl/pdps_power_clamp.sv
// Sum, fixed-point scaling toward zero and magnitude clamp of the drive power.
// Depends on pdps_pkg for the limit struct and the power width.
`timescale 1ns / 1ps

module pdps_power_clamp #(
    parameter int POS_W     = 16,
    parameter int INT_W     = 24,
    parameter int FRAC_BITS = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_en_sum,
    input  logic                                         i_en_out,
    input  logic signed [POS_W+pdps_pkg::GAIN_W+1:0]     i_p_term,
    input  logic signed [INT_W+pdps_pkg::GAIN_W:0]       i_i_term,
    input  logic signed [POS_W+pdps_pkg::GAIN_W+2:0]     i_d_term,
    input  logic                                         i_zero,
    input  pdps_pkg::t_limit_cfg                         i_limit,
    output logic signed [pdps_pkg::POWER_W-1:0]          o_drive_power,
    output logic                                         o_settled
);
    import pdps_pkg::*;

    localparam int PE_W  = POS_W + GAIN_W + 2;
    localparam int PI_W  = INT_W + GAIN_W + 1;
    localparam int PD_W  = POS_W + GAIN_W + 3;
    localparam int MAX_W = (PI_W > PD_W) ? PI_W : PD_W;
    localparam int SUM_W = MAX_W + 2;
    localparam logic [SUM_W-1:0] BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_zero;
    logic signed [POWER_W-1:0] r_power, n_power;
    logic                      r_settled;

    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] power;
    logic signed [SUM_W-1:0] clamped;
    logic signed [SUM_W-1:0] maxp;
    logic signed [SUM_W-1:0] minp;

    always_comb begin
        n_sum = SUM_W'(i_p_term) + SUM_W'(i_i_term) + SUM_W'(i_d_term);
    end

    always_comb begin
        // Adding the fraction mask to a negative sum makes the shift round toward zero.
        biased = r_sum + (r_sum[SUM_W-1] ? $signed(BIAS) : $signed(SUM_W'(0)));
        power  = biased >>> FRAC_BITS;
        maxp   = $signed(SUM_W'(i_limit.mag_hi));
        minp   = $signed(SUM_W'(i_limit.mag_lo));
        clamped = power;
        if (power > 0) begin
            if (power > maxp) begin
                clamped = maxp;
            end else if (power < minp) begin
                clamped = minp;
            end
        end else if (power < 0) begin
            if (power < -maxp) begin
                clamped = -maxp;
            end else if (power > -minp) begin
                clamped = -minp;
            end
        end
        n_power = r_zero ? '0 : POWER_W'(clamped);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum  <= n_sum;
            r_zero <= i_zero;
        end
        if (i_en_out) begin
            r_power   <= n_power;
            r_settled <= r_zero;
        end
    end

    assign o_drive_power = r_power;
    assign o_settled     = r_settled;

endmodule

// File: hw/rtl/pid_position_drive_step.sv
// Top level of the PID position drive step: configuration registers, input
// register, pipeline flow control and the three datapath stages.
// Depends on pdps_pkg, pdps_err_integ, pdps_gain_mul and pdps_power_clamp.
//
// Usage: one encoder sample (position, restart) enters on the input channel
// per transaction, and one result (drive power, settled) leaves on the output
// channel for each of them, in order. A transaction completes on a rising edge
// with valid high and stall low. The pipeline has five registers: input,
// error/integral, gain products, sum and output. A new sample can be accepted
// every cycle while the receiver does not stall. The integral and previous
// error live in the error/integral stage and are updated as each sample
// passes through it, so back-to-back samples see the state left by the one
// before. When the receiver stalls, the stages fill up one after another and
// the input stall rises once the input register is occupied and cannot move
// on; nothing is dropped. Configuration writes take effect on the next edge;
// the user must make them while no sample is in flight, as the block does
// not enforce this. Reset empties the pipeline, clears the integral and
// previous error and loads the register reset values.
`timescale 1ns / 1ps

module pid_position_drive_step #(
    parameter int POSITION_WIDTH = 16,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [POSITION_WIDTH-1:0]     i_position,
    input  logic                                 i_restart,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pdps_pkg::POWER_W-1:0]  o_drive_power,
    output logic                                 o_settled,
    input  logic                                 i_cfg_we,
    input  logic [pdps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16)-1:0] i_cfg_data
);
    import pdps_pkg::*;

    localparam int PW   = POSITION_WIDTH;
    localparam int IW   = INTEGRAL_WIDTH;

    // Configuration registers.
    logic signed [PW-1:0]       r_target;
    logic [THRESH_W-1:0]        r_threshold;
    t_gain_cfg                  r_gain;
    t_limit_cfg                 r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target          <= '0;
            r_limit.mag_hi    <= MAX_POWER_RST;
            r_limit.mag_lo    <= MIN_POWER_RST;
            r_threshold       <= INT_THRESH_RST;
            r_gain.prop       <= PROP_GAIN_RST;
            r_gain.integ      <= INTEG_GAIN_RST;
            r_gain.deriv      <= DERIV_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TARGET:     r_target          <= $signed(i_cfg_data[PW-1:0]);
                REG_MAX_POWER:  r_limit.mag_hi    <= i_cfg_data[LIMIT_W-1:0];
                REG_MIN_POWER:  r_limit.mag_lo    <= i_cfg_data[LIMIT_W-1:0];
                REG_INT_THRESH: r_threshold       <= i_cfg_data[THRESH_W-1:0];
                REG_PROP_GAIN:  r_gain.prop       <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: r_gain.integ      <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: r_gain.deriv      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits; stage 4 is the output register.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic en0, en1, en2, en3, en4;

    // A stage may load when it is empty or when its contents move on.
    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign en0     = !r_v0 || en1;
    assign o_stall = !en0;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Input register.
    logic signed [PW-1:0] r_position;
    logic                 r_restart;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_position <= i_position;
            r_restart  <= i_restart;
        end
    end

    logic signed [PW:0]                s1_err;
    logic signed [IW-1:0]              s1_integral;
    logic signed [PW+1:0]              s1_deriv;
    logic                              s1_zero;
    logic signed [PW+GAIN_W+1:0]       s2_p_term;
    logic signed [IW+GAIN_W:0]         s2_i_term;
    logic signed [PW+GAIN_W+2:0]       s2_d_term;
    logic                              s2_zero;

    pdps_err_integ #(
        .POS_W (PW),
        .INT_W (IW)
    ) u_err_integ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (en1 && r_v0),
        .i_position  (r_position),
        .i_restart   (r_restart),
        .i_target    (r_target),
        .i_threshold (r_threshold),
        .o_err       (s1_err),
        .o_integral  (s1_integral),
        .o_deriv     (s1_deriv),
        .o_zero      (s1_zero)
    );

    pdps_gain_mul #(
        .POS_W (PW),
        .INT_W (IW)
    ) u_gain_mul (
        .i_clk      (i_clk),
        .i_en       (en2),
        .i_err      (s1_err),
        .i_integral (s1_integral),
        .i_deriv    (s1_deriv),
        .i_zero     (s1_zero),
        .i_gain     (r_gain),
        .o_p_term   (s2_p_term),
        .o_i_term   (s2_i_term),
        .o_d_term   (s2_d_term),
        .o_zero     (s2_zero)
    );

    pdps_power_clamp #(
        .POS_W     (PW),
        .INT_W     (IW),
        .FRAC_BITS (GAIN_FRAC_BITS)
    ) u_power_clamp (
        .i_clk         (i_clk),
        .i_en_sum      (en3),
        .i_en_out      (en4),
        .i_p_term      (s2_p_term),
        .i_i_term      (s2_i_term),
        .i_d_term      (s2_d_term),
        .i_zero        (s2_zero),
        .i_limit       (r_limit),
        .o_drive_power (o_drive_power),
        .o_settled     (o_settled)
    );

    a_settled_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_settled |-> o_drive_power == '0)
        else $error("settled result carries nonzero power");

    a_power_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive_power != {1'b1, {(POWER_W-1){1'b0}}})
        else $error("drive power magnitude out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v0 && r_v1 && r_v2 && r_v3 && r_v4)
        else $error("input stalled with room in the pipeline");

    a_sum_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_stall |=> o_valid)
        else $error("finished sum did not reach the output register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

// File: verif/tb_pid_position_drive_step.sv
// Self-checking testbench for pid_position_drive_step: drives encoder samples and
// register writes, predicts each drive result in place and compares it on arrival.
// Depends on pdps_pkg and the pid_position_drive_step RTL.
`timescale 1ns / 1ps

module tb_pid_position_drive_step;

    import pdps_pkg::*;

    localparam int     POS_W         = 16;
    localparam int     CLK_PERIOD    = 4;
    localparam int     RESET_CYCLES  = 11;
    localparam int     HOLD_CYCLES   = 64;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     RUN_LIMIT_NS  = 2_000_000;
    localparam longint GAIN_SCALE    = 256;
    localparam longint INTEGRAL_MAX  = (longint'(1) <<< 23) - 1;
    localparam longint INTEGRAL_MIN  = -INTEGRAL_MAX - 1;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;

    typedef struct {
        logic signed [POWER_W-1:0] power;
        logic                      settled;
    } t_drive_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [POS_W-1:0]       i_position = '0;
    logic                          i_restart = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [POWER_W-1:0]     o_drive_power;
    logic                          o_settled;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [15:0]                   i_cfg_data = '0;

    pid_position_drive_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_position    (i_position),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive_power (o_drive_power),
        .o_settled     (o_settled),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor copy of the registers and of the controller state.
    logic signed [POS_W-1:0]  m_target     = '0;
    logic [LIMIT_W-1:0]       m_mag_hi     = MAX_POWER_RST;
    logic [LIMIT_W-1:0]       m_mag_lo     = MIN_POWER_RST;
    logic [THRESH_W-1:0]      m_int_thresh = INT_THRESH_RST;
    t_gain_cfg                m_gain       = '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST};
    longint                   m_integral   = 0;
    longint                   m_prev_error = 0;

    t_drive_result expected_drive[$];
    int            mismatches = 0;
    int            results_seen = 0;

    // Sender and receiver idling controls.
    bit            gaps_on = 1'b0;
    int            burst_left = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    bit            hold_request = 1'b0;
    int            hold_left = 0;
    logic [7:0]    stall_pattern = 8'b1100_1010;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_drive_result predict_drive_step(input logic signed [POS_W-1:0] pos,
                                                         input logic restart);
        longint        err;
        longint        deriv;
        longint        sum;
        longint        power;
        longint        maxp;
        longint        minp;
        t_drive_result res;
        maxp = longint'(m_mag_hi);
        minp = longint'(m_mag_lo);
        if (restart) begin
            m_integral   = 0;
            m_prev_error = 0;
        end
        err = longint'(m_target) - longint'(pos);
        // Only a positive error above the threshold clears the integral.
        if (err > longint'(m_int_thresh)) begin
            m_integral = 0;
        end else begin
            m_integral = m_integral + err;
            if (m_integral > INTEGRAL_MAX) m_integral = INTEGRAL_MAX;
            if (m_integral < INTEGRAL_MIN) m_integral = INTEGRAL_MIN;
        end
        deriv        = err - m_prev_error;
        m_prev_error = err;
        sum = err * longint'(m_gain.prop) + m_integral * longint'(m_gain.integ)
            + deriv * longint'(m_gain.deriv);
        power = sum / GAIN_SCALE;
        // The max check comes first, so min above max still yields max for large power.
        if (power > 0) begin
            if (power > maxp) power = maxp;
            else if (power < minp) power = minp;
        end else if (power < 0) begin
            if (power < -maxp) power = -maxp;
            else if (power > -minp) power = -minp;
        end
        res.settled = (err == 0);
        res.power   = (err == 0) ? '0 : power[POWER_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_drive.size() == 0) begin
                report_mismatch($sformatf("unexpected result power %0d settled %0b",
                                          o_drive_power, o_settled));
            end else begin
                want = expected_drive.pop_front();
                if (o_drive_power !== want.power)
                    report_mismatch($sformatf("drive_power %0d, expected %0d",
                                              o_drive_power, want.power));
                if (o_settled !== want.settled)
                    report_mismatch($sformatf("settled %0b, expected %0b",
                                              o_settled, want.settled));
            end
            results_seen++;
        end
    end

    // Receiver: a long hold-off on request, otherwise the current stall pattern.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                    STALL_PATTERN: begin
                        i_stall <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                    default: i_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic send_sample(input logic signed [POS_W-1:0] pos, input logic restart);
        int gap;
        i_valid    <= 1'b1;
        i_position <= pos;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_stall);
        expected_drive.push_back(predict_drive_step(pos, restart));
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 7);
            burst_left = $urandom_range(0, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_TARGET:     m_target     = data;
            REG_MAX_POWER:  m_mag_hi     = data[LIMIT_W-1:0];
            REG_MIN_POWER:  m_mag_lo     = data[LIMIT_W-1:0];
            REG_INT_THRESH: m_int_thresh = data;
            REG_PROP_GAIN:  m_gain.prop  = data;
            REG_INTEG_GAIN: m_gain.integ = data;
            REG_DERIV_GAIN: m_gain.deriv = data;
            default: ;
        endcase
    endtask

    // Loads every register once the pipeline has emptied. The power limits get random
    // upper bits, which the block must drop, and the spare index gets random data.
    task automatic load_config(input logic signed [POS_W-1:0] tgt,
                               input logic [LIMIT_W-1:0] maxp, input logic [LIMIT_W-1:0] minp,
                               input logic [15:0] thr, input logic [15:0] pg,
                               input logic [15:0] ig, input logic [15:0] dg);
        wait_idle();
        write_reg(REG_TARGET, tgt);
        write_reg(REG_MAX_POWER, {9'($urandom), maxp});
        write_reg(REG_MIN_POWER, {9'($urandom), minp});
        write_reg(REG_INT_THRESH, thr);
        write_reg(REG_PROP_GAIN, pg);
        write_reg(REG_INTEG_GAIN, ig);
        write_reg(REG_DERIV_GAIN, dg);
        write_reg(REG_SPARE, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom_range(0, 511));
            2: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic signed [POS_W-1:0] tgt;
        logic [15:0]             thr;
        tgt = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 400)) - 200);
        thr = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        load_config(tgt, 7'($urandom), 7'($urandom), thr, pick_gain(), pick_gain(),
                    pick_gain());
    endtask

    // Mostly samples that walk around the target, so the integral builds up and the
    // error reaches zero; the rest are arbitrary positions.
    function automatic logic signed [POS_W-1:0] pick_position();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'($urandom);
        if (r < 30) return m_target;
        v = int'(m_target) + int'($urandom_range(0, 240)) - 120;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic pick_restart();
        return ($urandom_range(0, 15) == 0);
    endfunction

    task automatic test_reset_values();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    task automatic test_directed_corners();
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        // Every register at its top value but the min power, which is zero.
        load_config(16'sh7FFF, 7'd127, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd0, 1'b1);
        // Both limits zero squash every power to zero.
        load_config(16'sh8000, 7'd0, 7'd0, 16'd0, 16'd256, 16'd0, 16'd0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        // Min power above max power, both signs.
        load_config(16'sd0, 7'd20, 7'd100, 16'd50, 16'd256, 16'd0, 16'd0);
        send_sample(-16'sd10, 1'b0);
        send_sample(-16'sd50, 1'b0);
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd50, 1'b0);
        // Truncation toward zero, including a nonzero error with zero power.
        load_config(16'sd0, 7'd127, 7'd0, 16'd50, 16'd3, 16'd0, 16'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd85, 1'b0);
        // Integral clearing on the positive side only, and the derivative term.
        load_config(16'sd0, 7'd127, 7'd0, 16'd50, 16'd0, 16'd256, 16'd256);
        send_sample(-16'sd60, 1'b1);
        send_sample(-16'sd40, 1'b0);
        send_sample(16'sd60, 1'b0);
        send_sample(-16'sd51, 1'b0);
    endtask

    // Drives the integral into both saturation limits; with a unit integral gain the
    // zero crossing on the way down shows whether the top limit was held exactly.
    task automatic test_integral_saturation();
        gaps_on    = 1'b1;
        stall_mode = STALL_PATTERN;
        load_config(16'sh7FFF, 7'd127, 7'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0);
        send_sample(16'sh8000, 1'b1);
        repeat (134) send_sample(16'sh8000, 1'b0);
        stall_mode = STALL_RANDOM;
        load_config(16'sh8000, 7'd127, 7'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0);
        repeat (265) send_sample(16'sh7FFF, 1'b0);
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_receiver_holdoff();
        random_config();
        gaps_on      = 1'b0;
        stall_mode   = STALL_NONE;
        hold_request = 1'b1;
        repeat (40) send_sample(pick_position(), pick_restart());
    endtask

    // The sender stops until every result is back, then carries on with the same state.
    task automatic test_sender_pause();
        random_config();
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        repeat (3) begin
            repeat (15) send_sample(pick_position(), pick_restart());
            wait_idle();
        end
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_config(16'sh7FFF, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF);
                1: load_config(16'sh8000, 7'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                default: random_config();
            endcase
            stall_mode = t_stall_mode'(phase % 3);
            gaps_on    = (phase % 2 == 0);
            burst_left = 0;
            repeat (55) send_sample(pick_position(), pick_restart());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_directed_corners();
        test_integral_saturation();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_settings();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
